[rtl/bsrd_pkg.sv]
// shared types and constants for the battery sleep / relax detector
package bsrd_pkg;

	// register indexes on the configuration port
	typedef enum logic [2:0] {
		REG_ENTER_THRESH = 3'd0,
		REG_ENTER_COUNT  = 3'd1,
		REG_EXIT_THRESH  = 3'd2,
		REG_EXIT_COUNT   = 3'd3,
		REG_RELAX_SECS   = 3'd4
	} reg_index_t;

	localparam int CurrentWidth = 16;
	localparam int MagWidth     = 17;
	localparam int ThreshWidth  = 15;
	localparam int CountWidth   = 8;
	localparam int PeriodWidth  = 16;
	localparam int TimeWidth    = 32;
	localparam int CfgDataWidth = 16;
	localparam int InDataWidth  = 72;
	localparam int OutDataWidth = 40;

	localparam logic [ThreshWidth-1:0] ResetEnterCurrent = 15'd10;
	localparam logic [CountWidth-1:0]  ResetEnterSamples = 8'd4;
	localparam logic [ThreshWidth-1:0] ResetExitCurrent  = 15'd20;
	localparam logic [CountWidth-1:0]  ResetExitSamples  = 8'd4;
	localparam logic [PeriodWidth-1:0] ResetRelaxPeriod  = 16'd1800;
	localparam logic [CountWidth-1:0]  CountMax          = '1;

	typedef struct packed {
		logic [ThreshWidth-1:0] enter_thresh;
		logic [CountWidth-1:0]  enter_count;
		logic [ThreshWidth-1:0] exit_thresh;
		logic [CountWidth-1:0]  exit_count;
		logic [PeriodWidth-1:0] relax_secs;
	} cfg_t;

	typedef struct packed {
		logic                           clear_sleep_total;
		logic [TimeWidth-1:0]           now_seconds;
		logic signed [CurrentWidth-1:0] average_current;
		logic signed [CurrentWidth-1:0] instant_current;
	} sample_t;

	typedef struct packed {
		logic [TimeWidth-1:0] sleep_seconds_total;
		logic                 calibrate_pulse;
		logic                 is_sleeping;
		logic                 is_relaxed;
	} result_t;

	// magnitude of a 16-bit two's complement current, minus full scale gives 32768
	function automatic logic [MagWidth-1:0] magnitude(input logic [CurrentWidth-1:0] raw);
		logic [MagWidth-1:0] ext;
		ext = {1'b0, raw};
		if (raw[CurrentWidth-1]) begin
			return (MagWidth'(1) << CurrentWidth) - ext;
		end
		return ext;
	endfunction

endpackage

[rtl/bsrd_cfg.sv]
// configuration registers of the detector
module bsrd_cfg (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_wen,
	input  logic [2:0]                           cfg_index,
	input  logic [bsrd_pkg::CfgDataWidth-1:0]    cfg_wdata,
	output bsrd_pkg::cfg_t                       cfg
);

	bsrd_pkg::cfg_t cfg_q;

	// register writes, unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enter_thresh <= bsrd_pkg::ResetEnterCurrent;
			cfg_q.enter_count  <= bsrd_pkg::ResetEnterSamples;
			cfg_q.exit_thresh  <= bsrd_pkg::ResetExitCurrent;
			cfg_q.exit_count   <= bsrd_pkg::ResetExitSamples;
			cfg_q.relax_secs   <= bsrd_pkg::ResetRelaxPeriod;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				bsrd_pkg::REG_ENTER_THRESH: begin
					cfg_q.enter_thresh <= cfg_wdata[bsrd_pkg::ThreshWidth-1:0];
				end
				bsrd_pkg::REG_ENTER_COUNT: begin
					cfg_q.enter_count <= cfg_wdata[bsrd_pkg::CountWidth-1:0];
				end
				bsrd_pkg::REG_EXIT_THRESH: begin
					cfg_q.exit_thresh <= cfg_wdata[bsrd_pkg::ThreshWidth-1:0];
				end
				bsrd_pkg::REG_EXIT_COUNT: begin
					cfg_q.exit_count <= cfg_wdata[bsrd_pkg::CountWidth-1:0];
				end
				bsrd_pkg::REG_RELAX_SECS: begin
					cfg_q.relax_secs <= cfg_wdata[bsrd_pkg::PeriodWidth-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[rtl/bsrd_core.sv]
// detector state and the per-sample update logic
module bsrd_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  bsrd_pkg::sample_t sample,
	input  bsrd_pkg::cfg_t    cfg,
	output bsrd_pkg::result_t result
);

	logic                                sleeping_q;
	logic                                relaxed_q;
	logic [bsrd_pkg::CountWidth-1:0]     count_q;
	logic [bsrd_pkg::TimeWidth-1:0]      start_q;
	logic [bsrd_pkg::TimeWidth-1:0]      last_q;
	logic [bsrd_pkg::TimeWidth-1:0]      total_q;

	logic                                sleeping_d;
	logic                                relaxed_d;
	logic [bsrd_pkg::CountWidth-1:0]     count_d;
	logic [bsrd_pkg::TimeWidth-1:0]      start_d;
	logic [bsrd_pkg::TimeWidth-1:0]      last_d;
	logic [bsrd_pkg::TimeWidth-1:0]      total_d;
	logic                                pulse;

	logic [bsrd_pkg::MagWidth-1:0]       inst_mag;
	logic [bsrd_pkg::MagWidth-1:0]       avg_mag;
	logic [bsrd_pkg::CountWidth-1:0]     count_inc;
	logic [bsrd_pkg::TimeWidth-1:0]      total_base;
	logic [bsrd_pkg::TimeWidth-1:0]      since_start;

	assign inst_mag    = bsrd_pkg::magnitude(sample.instant_current);
	assign avg_mag     = bsrd_pkg::magnitude(sample.average_current);
	assign count_inc   = (count_q == bsrd_pkg::CountMax) ? count_q : count_q + 1'b1;
	assign total_base  = sample.clear_sleep_total ? '0 : total_q;
	assign since_start = sample.now_seconds - start_q;

	// next state for one sample
	always_comb begin
		sleeping_d = sleeping_q;
		relaxed_d  = relaxed_q;
		count_d    = count_q;
		start_d    = start_q;
		last_d     = last_q;
		total_d    = total_base;
		pulse      = 1'b0;
		if (!sleeping_q) begin
			// awake: count quiet samples toward sleep
			if (inst_mag <= {2'b00, cfg.enter_thresh}) begin
				count_d = count_inc;
				if (count_inc >= cfg.enter_count) begin
					start_d    = sample.now_seconds;
					last_d     = sample.now_seconds;
					sleeping_d = 1'b1;
					pulse      = 1'b1;
				end
			end else begin
				count_d = '0;
			end
		end else begin
			// asleep: accumulate time, watch for busy current or relax
			total_d = total_base + (sample.now_seconds - last_q);
			last_d  = sample.now_seconds;
			if (avg_mag > {2'b00, cfg.exit_thresh}) begin
				if (inst_mag > {2'b00, cfg.exit_thresh}) begin
					count_d = count_inc;
				end else begin
					count_d = '0;
				end
				if (count_d > cfg.exit_count) begin
					start_d    = '0;
					sleeping_d = 1'b0;
					relaxed_d  = 1'b0;
				end
			end else begin
				count_d = '0;
				if (!relaxed_q && since_start > {16'd0, cfg.relax_secs}) begin
					relaxed_d = 1'b1;
					pulse     = 1'b1;
				end
			end
		end
	end

	// state registers, advanced once per transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sleeping_q <= 1'b0;
			relaxed_q  <= 1'b0;
			count_q    <= '0;
			start_q    <= '0;
			last_q     <= '0;
			total_q    <= '0;
		end else if (step) begin
			sleeping_q <= sleeping_d;
			relaxed_q  <= relaxed_d;
			count_q    <= count_d;
			start_q    <= start_d;
			last_q     <= last_d;
			total_q    <= total_d;
		end
	end

	assign result.is_relaxed          = relaxed_d;
	assign result.is_sleeping         = sleeping_d;
	assign result.calibrate_pulse     = pulse;
	assign result.sleep_seconds_total = total_d;

	// relax only exists while asleep
	a_relax_needs_sleep: assert property (@(posedge clk) disable iff (!arst_n)
		relaxed_q |-> sleeping_q)
		else $error("relax flag set while awake");

	// a calibrate pulse leaves the block asleep
	a_pulse_sleeping: assert property (@(posedge clk) disable iff (!arst_n)
		(step && pulse) |=> sleeping_q)
		else $error("calibrate pulse without sleep");

	// waking clears relax and the sleep entry time
	a_wake_clears: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(sleeping_q) |-> (!relaxed_q && start_q == '0))
		else $error("wake left relax or entry time behind");

	// state only moves on a transaction
	a_hold_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!step |=> $stable(total_q) && $stable(sleeping_q))
		else $error("state changed without a transaction");

endmodule

[rtl/battery_sleep_relax_detector.sv]
// top level of the battery sleep / relax detector
// One sample is accepted per clock unless stalled: it lands in an input register, then the
// compare and update logic advances the sleep state and loads the result register, so the
// block sustains one sample per cycle while the result stream keeps taking results.
// Either register stalls only when the result register is full and not being taken.
// Configuration writes take effect at the following clock edge; there is no read-back.
module battery_sleep_relax_detector (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// configuration write port
	input  logic                                  cfg_wen,
	input  logic [2:0]                            cfg_index,
	input  logic [bsrd_pkg::CfgDataWidth-1:0]     cfg_wdata,
	// sample stream
	input  logic                                  s_axis_tvalid,
	output logic                                  s_axis_tready,
	// instant_current[15:0], average_current[31:16], now_seconds[63:32],
	// clear_sleep_total[64], zero fill [71:65]
	input  logic [bsrd_pkg::InDataWidth-1:0]      s_axis_tdata,
	// result stream
	output logic                                  m_axis_tvalid,
	input  logic                                  m_axis_tready,
	// is_relaxed[0], is_sleeping[1], calibrate_pulse[2], sleep_seconds_total[34:3],
	// zero fill [39:35]
	output logic [bsrd_pkg::OutDataWidth-1:0]     m_axis_tdata
);

	bsrd_pkg::cfg_t    cfg;
	bsrd_pkg::sample_t sample_s1;
	logic              valid_s1;
	bsrd_pkg::result_t result;
	bsrd_pkg::result_t result_s2;
	logic              valid_s2;
	logic              advance;

	bsrd_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// handshake: the result register frees when empty or taken
	assign advance       = !valid_s2 || m_axis_tready;
	assign s_axis_tready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			sample_s1 <= s_axis_tdata[$bits(bsrd_pkg::sample_t)-1:0];
		end
	end

	bsrd_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (valid_s1 && advance),
		.sample (sample_s1),
		.cfg    (cfg),
		.result (result)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			result_s2 <= result;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {{(bsrd_pkg::OutDataWidth - $bits(bsrd_pkg::result_t)){1'b0}},
		result_s2};

endmodule

[tb/testbench.sv]
// self-checking testbench for the battery sleep / relax detector
`timescale 1ns / 100ps

module testbench;

	// tracks detector state and the status words it must produce, in order
	class sleep_scoreboard;
		bsrd_pkg::cfg_t    cfg;
		logic              asleep;
		logic              relaxed;
		logic [7:0]        run_count;
		logic [31:0]       sleep_start;
		logic [31:0]       last_seen;
		logic [31:0]       sleep_total;
		bsrd_pkg::result_t expected_status_q[$];
		int                errors;
		int                samples;
		int                status_words;
		int                sleep_entries;
		int                wakes;
		int                relax_events;

		function new();
			cfg.enter_thresh = bsrd_pkg::ResetEnterCurrent;
			cfg.enter_count  = bsrd_pkg::ResetEnterSamples;
			cfg.exit_thresh  = bsrd_pkg::ResetExitCurrent;
			cfg.exit_count   = bsrd_pkg::ResetExitSamples;
			cfg.relax_secs   = bsrd_pkg::ResetRelaxPeriod;
			asleep      = 1'b0;
			relaxed     = 1'b0;
			run_count   = '0;
			sleep_start = '0;
			last_seen   = '0;
			sleep_total = '0;
		endfunction

		// register write, upper data bits beyond the register width are dropped
		function void write_register(logic [2:0] idx, logic [15:0] val);
			case (idx)
			bsrd_pkg::REG_ENTER_THRESH: cfg.enter_thresh = val[14:0];
			bsrd_pkg::REG_ENTER_COUNT:  cfg.enter_count  = val[7:0];
			bsrd_pkg::REG_EXIT_THRESH:  cfg.exit_thresh  = val[14:0];
			bsrd_pkg::REG_EXIT_COUNT:   cfg.exit_count   = val[7:0];
			bsrd_pkg::REG_RELAX_SECS:   cfg.relax_secs   = val;
			default: ;
			endcase
		endfunction

		// two's complement magnitude, minus full scale maps to 32768
		function int unsigned current_mag(logic [15:0] raw);
			return raw[15] ? 32'h10000 - 32'(raw) : 32'(raw);
		endfunction

		// advance the state by one accepted sample and queue the status word it yields
		function void add_sample(bsrd_pkg::sample_t smp);
			int unsigned       inst_mag;
			int unsigned       avg_mag;
			logic [31:0]       since_entry;
			logic              pulse;
			bsrd_pkg::result_t want;
			inst_mag = current_mag(smp.instant_current);
			avg_mag  = current_mag(smp.average_current);
			pulse    = 1'b0;
			samples++;
			if (smp.clear_sleep_total)
				sleep_total = '0;
			if (!asleep) begin
				// awake: count quiet samples toward sleep
				if (inst_mag <= 32'(cfg.enter_thresh)) begin
					if (run_count != 8'hFF)
						run_count++;
					if (run_count >= cfg.enter_count) begin
						sleep_start = smp.now_seconds;
						last_seen   = smp.now_seconds;
						asleep      = 1'b1;
						pulse       = 1'b1;
						sleep_entries++;
					end
				end else begin
					run_count = '0;
				end
			end else begin
				// asleep: accumulate time, then look for busy samples or relax
				sleep_total = sleep_total + (smp.now_seconds - last_seen);
				last_seen   = smp.now_seconds;
				if (avg_mag > 32'(cfg.exit_thresh)) begin
					if (inst_mag > 32'(cfg.exit_thresh)) begin
						if (run_count != 8'hFF)
							run_count++;
					end else begin
						run_count = '0;
					end
					if (run_count > cfg.exit_count) begin
						sleep_start = '0;
						asleep      = 1'b0;
						relaxed     = 1'b0;
						wakes++;
					end
				end else begin
					run_count   = '0;
					since_entry = smp.now_seconds - sleep_start;
					if (!relaxed && since_entry > 32'(cfg.relax_secs)) begin
						relaxed = 1'b1;
						pulse   = 1'b1;
						relax_events++;
					end
				end
			end
			want.is_relaxed          = relaxed;
			want.is_sleeping         = asleep;
			want.calibrate_pulse     = pulse;
			want.sleep_seconds_total = sleep_total;
			expected_status_q.push_back(want);
		endfunction

		// compare one status word from the block with the oldest expectation
		function void check_status(bsrd_pkg::result_t got);
			bsrd_pkg::result_t want;
			status_words++;
			if (expected_status_q.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("extra status word: rel=%0b slp=%0b cal=%0b tot=%0d",
						got.is_relaxed, got.is_sleeping, got.calibrate_pulse,
						got.sleep_seconds_total);
				return;
			end
			want = expected_status_q.pop_front();
			if (got.is_relaxed !== want.is_relaxed || got.is_sleeping !== want.is_sleeping ||
				got.calibrate_pulse !== want.calibrate_pulse ||
				got.sleep_seconds_total !== want.sleep_seconds_total) begin
				errors++;
				if (errors <= 10) begin
					$display("status word %0d mismatch: expected rel=%0b slp=%0b cal=%0b tot=%0d",
						status_words, want.is_relaxed, want.is_sleeping,
						want.calibrate_pulse, want.sleep_seconds_total);
					$display("  actual rel=%0b slp=%0b cal=%0b tot=%0d",
						got.is_relaxed, got.is_sleeping, got.calibrate_pulse,
						got.sleep_seconds_total);
				end
			end
		endfunction

		function int pending();
			return expected_status_q.size();
		endfunction
	endclass

	typedef enum {MODE_QUIET, MODE_BUSY, MODE_MIXED, MODE_NOISE} stim_mode_t;

	logic                              clk = 1'b0;
	logic                              arst_n = 1'b0;
	logic                              cfg_wen = 1'b0;
	logic [2:0]                        cfg_index = '0;
	logic [bsrd_pkg::CfgDataWidth-1:0] cfg_wdata = '0;
	logic                              s_axis_tvalid = 1'b0;
	logic                              s_axis_tready;
	logic [bsrd_pkg::InDataWidth-1:0]  s_axis_tdata = '0;
	logic                              m_axis_tvalid;
	logic                              m_axis_tready = 1'b0;
	logic [bsrd_pkg::OutDataWidth-1:0] m_axis_tdata;

	sleep_scoreboard sb = new();
	int              src_idle_pct = 0;
	int              sink_idle_pct = 0;
	int              pressure_req = 0;
	int              pressure_seen = 0;
	int              hold_left = 0;
	logic [31:0]     now_s = '0;

	battery_sleep_relax_detector DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wen       (cfg_wen),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always #5 clk = ~clk;

	// result side ready, with random stalls and a long hold-off on request
	always @(posedge clk) begin
		if (pressure_req != pressure_seen) begin
			pressure_seen <= pressure_req;
			hold_left     <= 300;
			m_axis_tready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left     <= hold_left - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
		end
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_status(bsrd_pkg::result_t'(m_axis_tdata[$bits(bsrd_pkg::result_t)-1:0]));
	end

	// offer one sample, idling first at random, and return once the transaction is taken
	task automatic send_sample(input logic signed [15:0] inst, input logic signed [15:0] avg,
		input logic [31:0] now, input logic clr);
		bsrd_pkg::sample_t smp;
		smp.instant_current   = inst;
		smp.average_current   = avg;
		smp.now_seconds       = now;
		smp.clear_sleep_total = clr;
		while ($urandom_range(0, 99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= bsrd_pkg::InDataWidth'(smp);
		do
			@(posedge clk);
		while (!(s_axis_tvalid && s_axis_tready));
		sb.add_sample(smp);
	endtask

	task automatic write_register(input logic [2:0] idx, input logic [15:0] val);
		cfg_wen   <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_wen <= 1'b0;
		sb.write_register(idx, val);
		@(posedge clk);
	endtask

	// stop offering and let every outstanding status word come back
	task automatic wait_for_results();
		s_axis_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// a current with the given magnitude and random sign
	function automatic logic signed [15:0] with_magnitude(input int unsigned mag);
		logic signed [15:0] v;
		v = 16'(mag);
		if (mag >= 32768)
			return 16'sh8000;
		return ($urandom_range(0, 1) != 0) ? -v : v;
	endfunction

	// magnitude in a range, leaning on both ends
	function automatic int unsigned pick_magnitude(input int unsigned lo, input int unsigned hi);
		int unsigned r;
		r = $urandom_range(0, 3);
		if (r == 0)
			return lo;
		if (r == 1)
			return hi;
		return $urandom_range(lo, hi);
	endfunction

	function automatic int run_length(input int unsigned count);
		if ($urandom_range(0, 1) != 0)
			return $urandom_range(count + 1, count + 6);
		return $urandom_range(1, count + 6);
	endfunction

	// runs of quiet, busy and mixed samples with noise in between, time moving on
	task automatic run_random_phase(input int n_items);
		stim_mode_t  mode;
		int          run_left;
		int unsigned enter_cur;
		int unsigned exit_cur;
		int unsigned pick;
		int unsigned relax;
		logic signed [15:0] inst;
		logic signed [15:0] avg;
		logic [31:0] step;
		enter_cur = 32'(sb.cfg.enter_thresh);
		exit_cur  = 32'(sb.cfg.exit_thresh);
		relax     = 32'(sb.cfg.relax_secs);
		mode      = MODE_QUIET;
		run_left  = 0;
		for (int i = 0; i < n_items; i++) begin
			if (run_left == 0) begin
				pick = $urandom_range(0, 99);
				if (pick < 40) begin
					mode     = MODE_QUIET;
					run_left = run_length(32'(sb.cfg.enter_count));
				end else if (pick < 70) begin
					mode     = MODE_BUSY;
					run_left = run_length(32'(sb.cfg.exit_count));
				end else if (pick < 85) begin
					mode     = MODE_MIXED;
					run_left = $urandom_range(1, 6);
				end else begin
					mode     = MODE_NOISE;
					run_left = $urandom_range(1, 6);
				end
			end
			run_left--;
			case (mode)
			MODE_QUIET: begin
				inst = with_magnitude(pick_magnitude(0, enter_cur));
				avg  = with_magnitude(pick_magnitude(0, exit_cur));
			end
			MODE_BUSY: begin
				inst = with_magnitude(pick_magnitude(exit_cur + 1, 32768));
				avg  = with_magnitude(pick_magnitude(exit_cur + 1, 32768));
			end
			MODE_MIXED: begin
				if ($urandom_range(0, 1) != 0) begin
					inst = with_magnitude(pick_magnitude(0, exit_cur));
					avg  = with_magnitude(pick_magnitude(exit_cur + 1, 32768));
				end else begin
					inst = with_magnitude(pick_magnitude(exit_cur + 1, 32768));
					avg  = with_magnitude(pick_magnitude(0, exit_cur));
				end
			end
			default: begin
				inst = 16'($urandom);
				avg  = 16'($urandom);
			end
			endcase
			// mostly short steps, some past the relax period, a few arbitrary jumps
			pick = $urandom_range(0, 99);
			if (pick < 55)
				step = $urandom_range(0, relax / 8 + 5);
			else if (pick < 85)
				step = $urandom_range(0, relax + relax / 2 + 10);
			else if (pick < 93)
				step = '0;
			else
				step = $urandom;
			now_s = now_s + step;
			send_sample(inst, avg, now_s, $urandom_range(0, 99) < 4);
		end
	endtask

	initial begin
		int n_items;
		src_idle_pct = 30;
		sink_idle_pct <= 69;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed samples under the reset settings
		send_sample(16'sh8000, 16'sh7FFF, 32'd0, 1'b0);
		send_sample(16'sd10, -16'sd10, 32'd100, 1'b0);
		send_sample(-16'sd10, 16'sd0, 32'd101, 1'b0);
		send_sample(16'sd0, 16'sd5, 32'd102, 1'b0);
		send_sample(16'sd7, -16'sd7, 32'd103, 1'b0);
		send_sample(16'sd0, 16'sd0, 32'd1000, 1'b0);
		send_sample(16'sd3, 16'sd20, 32'd1903, 1'b0);
		send_sample(-16'sd3, -16'sd20, 32'd1904, 1'b0);
		send_sample(16'sd0, 16'sd0, 32'd1910, 1'b1);
		send_sample(16'sd21, -16'sd21, 32'd1920, 1'b0);
		send_sample(16'sd20, 16'sh7FFF, 32'd1930, 1'b0);
		for (int k = 0; k < 5; k++)
			send_sample(-16'sd21, 16'sd21, 32'd1940 + k, 1'b0);
		// sleep entered just before the time counter wraps, then left at once
		send_sample(16'sd11, 16'sd0, 32'hFFFF_FFEC, 1'b0);
		for (int k = 0; k < 4; k++)
			send_sample(-16'sd10, 16'sd3, 32'hFFFF_FFED + k, 1'b0);
		send_sample(16'sh7FFF, 16'sh8000, 32'h0000_0010, 1'b0);
		send_sample(16'sh8000, 16'sh8000, 32'h0000_0020, 1'b0);
		now_s = 32'h0000_0020;
		wait_for_results();

		// random phases, each under its own register setting
		for (int p = 0; p < 12; p++) begin
			case (p)
			0: ;
			1: begin
				write_register(bsrd_pkg::REG_ENTER_THRESH, 16'h0000);
				write_register(bsrd_pkg::REG_ENTER_COUNT, 16'h0000);
				write_register(bsrd_pkg::REG_EXIT_THRESH, 16'h0000);
				write_register(bsrd_pkg::REG_EXIT_COUNT, 16'h0000);
				write_register(bsrd_pkg::REG_RELAX_SECS, 16'h0000);
			end
			2: begin
				write_register(bsrd_pkg::REG_ENTER_THRESH, 16'hFFFF);
				write_register(bsrd_pkg::REG_ENTER_COUNT, 16'hFFFF);
				write_register(bsrd_pkg::REG_EXIT_THRESH, 16'd100);
				write_register(bsrd_pkg::REG_EXIT_COUNT, 16'd2);
				write_register(bsrd_pkg::REG_RELAX_SECS, 16'hFFFF);
			end
			3: begin
				// exit count at its ceiling: the block can never wake
				write_register(bsrd_pkg::REG_ENTER_THRESH, 16'd50);
				write_register(bsrd_pkg::REG_ENTER_COUNT, 16'd3);
				write_register(bsrd_pkg::REG_EXIT_THRESH, 16'h7FFF);
				write_register(bsrd_pkg::REG_EXIT_COUNT, 16'h00FF);
				write_register(bsrd_pkg::REG_RELAX_SECS, 16'd300);
			end
			default: begin
				write_register(bsrd_pkg::REG_ENTER_THRESH,
					{1'($urandom), 15'($urandom_range(0, 400))});
				write_register(bsrd_pkg::REG_ENTER_COUNT,
					{8'($urandom), 8'($urandom_range(0, 10))});
				write_register(bsrd_pkg::REG_EXIT_THRESH,
					{1'($urandom), 15'($urandom_range(0, 800))});
				write_register(bsrd_pkg::REG_EXIT_COUNT,
					{8'($urandom), 8'($urandom_range(0, 10))});
				write_register(bsrd_pkg::REG_RELAX_SECS, 16'($urandom_range(0, 3000)));
				// writes to unused indexes must leave the settings alone
				if (p == 5 || p == 9)
					for (int idx = int'(bsrd_pkg::REG_RELAX_SECS) + 1; idx < 8; idx++)
						write_register(3'(idx), 16'($urandom));
			end
			endcase

			if (p < 4) begin
				src_idle_pct = 30;
				sink_idle_pct <= 69;
			end else if (p < 8) begin
				src_idle_pct = 69;
				sink_idle_pct <= 30;
			end else begin
				src_idle_pct = 0;
				sink_idle_pct <= 0;
			end
			// long result-side hold-off while samples keep coming
			if (p == 8)
				pressure_req <= pressure_req + 1;

			if (sb.cfg.enter_count > 32 || sb.cfg.exit_count > 32)
				n_items = 280;
			else
				n_items = 85;
			run_random_phase(n_items);
			wait_for_results();
		end

		$display("checked %0d status words for %0d samples over 12 register settings",
			sb.status_words, sb.samples);
		$display("sleep entered %0d times, left %0d, relax reached %0d, %0d mismatches",
			sb.sleep_entries, sb.wakes, sb.relax_events, sb.errors);
		if (sb.errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

	// run limit
	initial begin
		#4_000_000;
		$display("timeout with %0d status words outstanding", sb.pending());
		$display("DONE: errors detected");
		$finish;
	end

endmodule
